// ----- sv/plane_normal_to_dip_direction_unit_macros.svh -----
// assertion macros for the plane normal to dip direction unit
`ifndef PLANE_NORMAL_TO_DIP_DIRECTION_UNIT_MACROS_SVH
`define PLANE_NORMAL_TO_DIP_DIRECTION_UNIT_MACROS_SVH

// same-cycle implication
`define PNDD_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define PNDD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- sv/pndd_pkg.sv -----
// shared constants, types and cordic helpers for the dip direction unit
package pndd_pkg;

   localparam int COMPONENT_BITS = 16;
   localparam int CORDIC_STAGES  = 16;
   localparam int SCALE_SHIFT    = (COMPONENT_BITS < 30) ? 30 - COMPONENT_BITS : 0;
   localparam int ROOT_W         = COMPONENT_BITS + SCALE_SHIFT;
   localparam int SUMSQ_W        = 2 * COMPONENT_BITS;
   localparam int REM_W          = 2 * ROOT_W;
   localparam int LANE_W         = ROOT_W + 3;
   localparam int ACC_W          = 25;
   localparam int BIT_IDX_W      = $clog2(ROOT_W);
   localparam int STAGE_IDX_W    = $clog2(CORDIC_STAGES);
   localparam int DIP_W          = 15;
   localparam int AZIM_W         = 16;
   localparam int ANGLE_W        = 14;
   localparam int PROD_W         = 30;

   localparam logic signed [ACC_W-1:0] QUARTER_TURN = 25'sd5898240;

   localparam logic [ANGLE_W-1:0] DEG_0   = 14'd0;
   localparam logic [ANGLE_W-1:0] DEG_90  = 14'd9000;
   localparam logic [AZIM_W-1:0]  AZ_90   = 16'd9000;
   localparam logic [AZIM_W-1:0]  AZ_180  = 16'd18000;
   localparam logic [AZIM_W-1:0]  AZ_270  = 16'd27000;
   localparam logic [AZIM_W-1:0]  AZ_360  = 16'd36000;

   typedef struct packed {
      logic found;
      logic x_zero;
      logic y_zero;
      logic z_zero;
      logic x_neg;
      logic y_neg;
      logic z_neg;
   } flags_type;

   typedef struct packed {
      flags_type         flags;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] az_sc;
      logic [ROOT_W-1:0] ax_sc;
      logic [ROOT_W-1:0] ay_sc;
   } sqrt_stage_type;

   typedef struct packed {
      logic signed [LANE_W-1:0] px;
      logic signed [LANE_W-1:0] py;
      logic signed [ACC_W-1:0]  acc;
   } lane_type;

   typedef struct packed {
      flags_type flags;
      lane_type  dip;
      lane_type  azim;
   } cordic_stage_type;

   // atan(2^-i) in degrees times 65536
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] i);
      logic signed [ACC_W-1:0] r;
      case (i)
         5'd0:    r = 25'sd2949120;
         5'd1:    r = 25'sd1740967;
         5'd2:    r = 25'sd919879;
         5'd3:    r = 25'sd466945;
         5'd4:    r = 25'sd234379;
         5'd5:    r = 25'sd117304;
         5'd6:    r = 25'sd58666;
         5'd7:    r = 25'sd29335;
         5'd8:    r = 25'sd14668;
         5'd9:    r = 25'sd7334;
         5'd10:   r = 25'sd3667;
         5'd11:   r = 25'sd1833;
         5'd12:   r = 25'sd917;
         5'd13:   r = 25'sd458;
         5'd14:   r = 25'sd229;
         5'd15:   r = 25'sd115;
         5'd16:   r = 25'sd57;
         5'd17:   r = 25'sd29;
         5'd18:   r = 25'sd14;
         5'd19:   r = 25'sd7;
         5'd20:   r = 25'sd4;
         5'd21:   r = 25'sd2;
         5'd22:   r = 25'sd1;
         default: r = 25'sd0;
      endcase
      return r;
   endfunction

   function automatic lane_type lane_step(input lane_type l,
                                          input logic [STAGE_IDX_W-1:0] i);
      lane_type                 n;
      logic signed [LANE_W-1:0] dx;
      logic signed [LANE_W-1:0] dy;
      dx = l.py >>> i;
      dy = l.px >>> i;
      if (l.py >= 0) begin
         n.px  = l.px + dx;
         n.py  = l.py - dy;
         n.acc = l.acc + atan_entry(5'(i));
      end else begin
         n.px  = l.px - dx;
         n.py  = l.py + dy;
         n.acc = l.acc - atan_entry(5'(i));
      end
      return n;
   endfunction

   // clamp to a quarter turn and round to hundredths
   function automatic logic [ANGLE_W-1:0] to_hundredths(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-1:0]  c;
      logic [PROD_W-1:0] p;
      if (acc < 0)
         c = '0;
      else if (acc > QUARTER_TURN)
         c = QUARTER_TURN;
      else
         c = acc;
      p = PROD_W'(c) * PROD_W'(100) + PROD_W'(32768);
      return p[PROD_W-1:16];
   endfunction

endpackage

// ----- sv/pndd_req_if.sv -----
// request channel carrying one plane normal per beat
interface pndd_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      plane_found;
   logic signed [pndd_pkg::COMPONENT_BITS-1:0] normal_x;
   logic signed [pndd_pkg::COMPONENT_BITS-1:0] normal_y;
   logic signed [pndd_pkg::COMPONENT_BITS-1:0] normal_z;

   modport source (output valid, plane_found, normal_x, normal_y, normal_z, input ready);
   modport sink   (input valid, plane_found, normal_x, normal_y, normal_z, output ready);
endinterface

// ----- sv/pndd_rsp_if.sv -----
// response channel carrying dip and dip direction per beat
interface pndd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              valid_res;
   logic signed [pndd_pkg::DIP_W-1:0] dip_angle;
   logic [pndd_pkg::AZIM_W-1:0]       dip_azimuth;

   modport source (output valid, valid_res, dip_angle, dip_azimuth, input ready);
   modport sink   (input valid, valid_res, dip_angle, dip_azimuth, output ready);
endinterface

// ----- sv/pndd_sqrt_cell.sv -----
// one result bit of the pipelined integer square root
module pndd_sqrt_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic [pndd_pkg::BIT_IDX_W-1:0]   bit_idx,
   input  logic                             in_valid,
   input  pndd_pkg::sqrt_stage_type         in_stage,
   output logic                             out_valid,
   output pndd_pkg::sqrt_stage_type         out_stage
);

   logic                              valid_ff;
   pndd_pkg::sqrt_stage_type          stage_ff;
   pndd_pkg::sqrt_stage_type          stage_in;
   logic [pndd_pkg::REM_W-1:0]        trial;

   always_comb begin
      trial = ((pndd_pkg::REM_W'(in_stage.root) << bit_idx) << 1)
            | ((pndd_pkg::REM_W'(1) << bit_idx) << bit_idx);
      stage_in = in_stage;
      if (in_stage.rem >= trial) begin
         stage_in.rem  = in_stage.rem - trial;
         stage_in.root = in_stage.root | (pndd_pkg::ROOT_W'(1) << bit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ----- sv/pndd_cordic_cell.sv -----
// one vectoring cordic rotation for the dip and the azimuth lanes
module pndd_cordic_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic [pndd_pkg::STAGE_IDX_W-1:0] stage_idx,
   input  logic                             in_valid,
   input  pndd_pkg::cordic_stage_type       in_stage,
   output logic                             out_valid,
   output pndd_pkg::cordic_stage_type       out_stage
);

   logic                          valid_ff;
   pndd_pkg::cordic_stage_type    stage_ff;
   pndd_pkg::cordic_stage_type    stage_in;

   always_comb begin
      stage_in.flags = in_stage.flags;
      stage_in.dip   = pndd_pkg::lane_step(in_stage.dip, stage_idx);
      stage_in.azim  = pndd_pkg::lane_step(in_stage.azim, stage_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ----- sv/plane_normal_to_dip_direction_unit.sv -----
// throughput: one normal per cycle unless stalled; abs, square, one cell per root bit, one per cordic step
// the whole row advances together and holds while a response beat waits to be taken
// reset: synchronous, clears every valid bit; data registers are not reset
`include "plane_normal_to_dip_direction_unit_macros.svh"
module plane_normal_to_dip_direction_unit (
   input  logic  clock,
   input  logic  reset,
   pndd_req_if.sink   req_chan,
   pndd_rsp_if.source rsp_chan
);

   localparam int CB = pndd_pkg::COMPONENT_BITS;

   logic enable;

   // abs stage
   logic                   s0_valid_ff;
   pndd_pkg::flags_type    s0_flags_ff;
   logic [CB-1:0]          s0_ax_ff, s0_ay_ff, s0_az_ff;

   // square stage
   logic                            s1_valid_ff;
   pndd_pkg::flags_type             s1_flags_ff;
   logic [pndd_pkg::SUMSQ_W-1:0]    s1_sumsq_ff;
   logic [CB-1:0]                   s1_ax_ff, s1_ay_ff, s1_az_ff;

   logic                        sq_valid [pndd_pkg::ROOT_W+1];
   pndd_pkg::sqrt_stage_type    sq_stage [pndd_pkg::ROOT_W+1];
   logic                        cd_valid [pndd_pkg::CORDIC_STAGES+1];
   pndd_pkg::cordic_stage_type  cd_stage [pndd_pkg::CORDIC_STAGES+1];

   logic                             rsp_valid_ff;
   logic                             valid_res_ff;
   logic signed [pndd_pkg::DIP_W-1:0] dip_ff, dip_in;
   logic [pndd_pkg::AZIM_W-1:0]      azim_ff, azim_in;
   logic [pndd_pkg::ANGLE_W-1:0]     dip_h, azim_h;
   pndd_pkg::flags_type              fin_flags;

   assign enable         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= req_chan.valid;
         s1_valid_ff <= s0_valid_ff;
      end
      if (enable) begin
         s0_flags_ff.found  <= req_chan.plane_found;
         s0_flags_ff.x_zero <= (req_chan.normal_x == '0);
         s0_flags_ff.y_zero <= (req_chan.normal_y == '0);
         s0_flags_ff.z_zero <= (req_chan.normal_z == '0);
         s0_flags_ff.x_neg  <= req_chan.normal_x[CB-1];
         s0_flags_ff.y_neg  <= req_chan.normal_y[CB-1];
         s0_flags_ff.z_neg  <= req_chan.normal_z[CB-1];
         s0_ax_ff <= req_chan.normal_x[CB-1] ? CB'(-req_chan.normal_x) : CB'(req_chan.normal_x);
         s0_ay_ff <= req_chan.normal_y[CB-1] ? CB'(-req_chan.normal_y) : CB'(req_chan.normal_y);
         s0_az_ff <= req_chan.normal_z[CB-1] ? CB'(-req_chan.normal_z) : CB'(req_chan.normal_z);
         s1_flags_ff <= s0_flags_ff;
         s1_sumsq_ff <= pndd_pkg::SUMSQ_W'(s0_ax_ff) * pndd_pkg::SUMSQ_W'(s0_ax_ff)
                      + pndd_pkg::SUMSQ_W'(s0_ay_ff) * pndd_pkg::SUMSQ_W'(s0_ay_ff);
         s1_ax_ff <= s0_ax_ff;
         s1_ay_ff <= s0_ay_ff;
         s1_az_ff <= s0_az_ff;
      end
   end

   always_comb begin
      sq_valid[0]       = s1_valid_ff;
      sq_stage[0].flags = s1_flags_ff;
      sq_stage[0].rem   = pndd_pkg::REM_W'(s1_sumsq_ff) << (2 * pndd_pkg::SCALE_SHIFT);
      sq_stage[0].root  = '0;
      sq_stage[0].az_sc = pndd_pkg::ROOT_W'(s1_az_ff) << pndd_pkg::SCALE_SHIFT;
      sq_stage[0].ax_sc = pndd_pkg::ROOT_W'(s1_ax_ff) << pndd_pkg::SCALE_SHIFT;
      sq_stage[0].ay_sc = pndd_pkg::ROOT_W'(s1_ay_ff) << pndd_pkg::SCALE_SHIFT;
   end

   for (genvar k = 0; k < pndd_pkg::ROOT_W; k++) begin : g_sqrt
      pndd_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .bit_idx   (pndd_pkg::BIT_IDX_W'(pndd_pkg::ROOT_W - 1 - k)),
         .in_valid  (sq_valid[k]),
         .in_stage  (sq_stage[k]),
         .out_valid (sq_valid[k+1]),
         .out_stage (sq_stage[k+1])
      );
   end

   always_comb begin
      cd_valid[0]          = sq_valid[pndd_pkg::ROOT_W];
      cd_stage[0].flags    = sq_stage[pndd_pkg::ROOT_W].flags;
      cd_stage[0].dip.px   = $signed({3'b000, sq_stage[pndd_pkg::ROOT_W].az_sc});
      cd_stage[0].dip.py   = $signed({3'b000, sq_stage[pndd_pkg::ROOT_W].root});
      cd_stage[0].dip.acc  = '0;
      cd_stage[0].azim.px  = $signed({3'b000, sq_stage[pndd_pkg::ROOT_W].ay_sc});
      cd_stage[0].azim.py  = $signed({3'b000, sq_stage[pndd_pkg::ROOT_W].ax_sc});
      cd_stage[0].azim.acc = '0;
   end

   for (genvar k = 0; k < pndd_pkg::CORDIC_STAGES; k++) begin : g_cordic
      pndd_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_idx (pndd_pkg::STAGE_IDX_W'(k)),
         .in_valid  (cd_valid[k]),
         .in_stage  (cd_stage[k]),
         .out_valid (cd_valid[k+1]),
         .out_stage (cd_stage[k+1])
      );
   end

   // final rounding and compass fold
   always_comb begin
      fin_flags = cd_stage[pndd_pkg::CORDIC_STAGES].flags;
      dip_h     = pndd_pkg::to_hundredths(cd_stage[pndd_pkg::CORDIC_STAGES].dip.acc);
      azim_h    = pndd_pkg::to_hundredths(cd_stage[pndd_pkg::CORDIC_STAGES].azim.acc);
      dip_in    = '0;
      azim_in   = '0;
      if (fin_flags.found && !(fin_flags.x_zero && fin_flags.y_zero)) begin
         if (fin_flags.z_zero) begin
            dip_in = pndd_pkg::DIP_W'(pndd_pkg::DEG_90);
         end else if (fin_flags.z_neg) begin
            dip_in = pndd_pkg::DIP_W'(-{1'b0, dip_h});
         end else begin
            dip_in = pndd_pkg::DIP_W'(dip_h);
         end
         if (fin_flags.y_zero) begin
            azim_in = fin_flags.x_neg ? pndd_pkg::AZ_270 : pndd_pkg::AZ_90;
         end else if (fin_flags.x_zero) begin
            azim_in = fin_flags.y_neg ? pndd_pkg::AZ_180 : pndd_pkg::AZIM_W'(pndd_pkg::DEG_0);
         end else if (!fin_flags.y_neg) begin
            azim_in = fin_flags.x_neg ? pndd_pkg::AZ_360 - pndd_pkg::AZIM_W'(azim_h)
                                      : pndd_pkg::AZIM_W'(azim_h);
         end else begin
            azim_in = fin_flags.x_neg ? pndd_pkg::AZ_180 + pndd_pkg::AZIM_W'(azim_h)
                                      : pndd_pkg::AZ_180 - pndd_pkg::AZIM_W'(azim_h);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= cd_valid[pndd_pkg::CORDIC_STAGES];
      end
      if (enable) begin
         valid_res_ff <= fin_flags.found;
         dip_ff       <= dip_in;
         azim_ff      <= azim_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.valid_res   = valid_res_ff;
   assign rsp_chan.dip_angle   = dip_ff;
   assign rsp_chan.dip_azimuth = azim_ff;

   `PNDD_ASSERT_NOW(a_no_plane_zero, rsp_valid_ff && !valid_res_ff, dip_ff == '0 && azim_ff == '0, "no-plane beat carries nonzero angles")
   `PNDD_ASSERT_NOW(a_angle_range, rsp_valid_ff, dip_ff <= $signed(pndd_pkg::DIP_W'(pndd_pkg::DEG_90)) && dip_ff >= -$signed(pndd_pkg::DIP_W'(pndd_pkg::DEG_90)) && azim_ff <= pndd_pkg::AZ_360, "angle out of range")
   `PNDD_ASSERT_NEXT(a_row_advance, enable && s1_valid_ff, sq_valid[1], "square stage beat lost entering the root row")

endmodule
